// ===== sv/fcce_pkg.sv =====
// fcce_pkg: types, codes and sizes shared by the floppy controller command engine.
// Depends on nothing; imported by fcce_core, fcce_rfifo and the top level.
`default_nettype none
package fcce_pkg;

    localparam int RESULT_DEPTH  = 16;
    localparam int PARAM_DEPTH   = 10;
    localparam int SHORT_DELAY   = 100;
    localparam int LONG_DELAY    = 500;
    localparam int READ_ID_DELAY = 4000;
    localparam int FINISH_DELAY  = 25;

    localparam int PTR_W   = $clog2(2 * RESULT_DEPTH);
    localparam int RIDX_W  = $clog2(RESULT_DEPTH);
    localparam int PIDX_W  = $clog2(PARAM_DEPTH);
    localparam int MAX_PUSH = 7;
    localparam int PCNT_W  = 3;

    localparam logic [3:0] ACT_BUS_WR  = 4'd0;
    localparam logic [3:0] ACT_BUS_RD  = 4'd1;
    localparam logic [3:0] ACT_TICK    = 4'd2;
    localparam logic [3:0] ACT_DISC    = 4'd3;
    localparam logic [3:0] ACT_DMA_RD  = 4'd4;
    localparam logic [3:0] ACT_DMA_WR  = 4'd5;
    localparam logic [3:0] ACT_NOTFND  = 4'd6;
    localparam logic [3:0] ACT_DATACRC = 4'd7;
    localparam logic [3:0] ACT_HDRCRC  = 4'd8;
    localparam logic [3:0] ACT_WPROT   = 4'd9;
    localparam logic [3:0] ACT_SECID   = 4'd10;
    localparam logic [3:0] ACT_FINISH  = 4'd11;
    localparam logic [3:0] ACT_FETCH   = 4'd12;

    localparam logic [2:0] OFF_DOR  = 3'd2;
    localparam logic [2:0] OFF_MSR  = 3'd4;
    localparam logic [2:0] OFF_FIFO = 3'd5;
    localparam logic [2:0] OFF_CCR  = 3'd7;

    localparam logic [2:0] RQ_NONE  = 3'd0;
    localparam logic [2:0] RQ_SEEK  = 3'd1;
    localparam logic [2:0] RQ_READ  = 3'd2;
    localparam logic [2:0] RQ_WRITE = 3'd3;
    localparam logic [2:0] RQ_RDID  = 3'd4;
    localparam logic [2:0] RQ_STOP  = 3'd5;
    localparam logic [2:0] RQ_SEL   = 3'd6;

    localparam logic [7:0] OP_SPECIFY     = 8'h03;
    localparam logic [7:0] OP_SENSE_DRIVE = 8'h04;
    localparam logic [7:0] OP_RECAL       = 8'h07;
    localparam logic [7:0] OP_SENSE_INT   = 8'h08;
    localparam logic [7:0] OP_READ_ID_FM  = 8'h0A;
    localparam logic [7:0] OP_DUMPREG     = 8'h0E;
    localparam logic [7:0] OP_SEEK        = 8'h0F;
    localparam logic [7:0] OP_CONFIGURE   = 8'h13;
    localparam logic [7:0] OP_WRITE       = 8'h45;
    localparam logic [7:0] OP_READ        = 8'h46;
    localparam logic [7:0] OP_READ_ID     = 8'h4A;
    localparam logic [7:0] OP_FORMAT      = 8'h4D;
    localparam logic [7:0] OP_VERIFY      = 8'h56;

    localparam int FL_TC = 3;
    localparam int FL_READY = 2;
    localparam int FL_WRITTEN = 1;
    localparam int FL_READING = 0;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [3:0] action;
        logic [2:0] reg_offset;
        byte_t      data_byte;
        logic       dma_terminal;
        byte_t      id_track;
        byte_t      id_side;
        byte_t      id_sector;
        byte_t      id_size;
        logic       fetch_last;
    } item_t;

    typedef struct packed {
        byte_t       output_reg;
        logic        reset_pending;
        byte_t       main_status;
        logic        busy;
        byte_t       opcode;
        byte_t [3:0] st;
        byte_t       cur_track;
        logic [8:0]  cur_sector;
        byte_t       cur_side;
        logic [3:0]  param_total;
        logic [3:0]  param_pos;
        byte_t       dma_byte;
        logic [1:0]  rate_density;
        logic        sel_drive;
        logic [3:0]  flags;
        logic [11:0] delay_count;
        logic [1:0]  levels;
    } state_t;

    typedef struct packed {
        byte_t      read_value;
        logic       fetch_valid;
        byte_t      fetch_value;
        logic       irq_line;
        logic       dma_line;
        logic [2:0] drive_request;
        logic       req_drive;
        byte_t      req_track;
        byte_t      req_sector;
        byte_t      req_side;
        logic [1:0] req_density;
        logic       command_error;
    } result_t;

    typedef struct packed {
        logic [PCNT_W-1:0]       cnt;
        byte_t [MAX_PUSH-1:0]    vals;
    } push_t;

    typedef struct packed {
        byte_t head;
        logic  empty;
        logic  one_left;
    } fifo_stat_t;

    function automatic push_t pushf(push_t q, byte_t v);
        push_t r;
        r = q;
        if (32'(q.cnt) < MAX_PUSH) begin
            r.vals[q.cnt] = v;
            r.cnt = q.cnt + PCNT_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/fcce_rfifo.sv =====
// fcce_rfifo: result FIFO storage, pointers and multi-push write logic.
// Depends on fcce_pkg.
`default_nettype none
module fcce_rfifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               pop,
    input  wire fcce_pkg::push_t    push_in,
    output fcce_pkg::fifo_stat_t    stat
);
    import fcce_pkg::*;

    byte_t mem_reg [RESULT_DEPTH];
    logic [PTR_W-1:0] rd_reg, wr_reg, wr_next;
    logic [PTR_W:0]   used;
    logic [PTR_W-1:0] ptr_k [MAX_PUSH];
    logic             wen_k [MAX_PUSH];

    function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
        return (32'(p) == 2 * RESULT_DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [RIDX_W-1:0] idx(logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] t;
        t = (32'(p) >= RESULT_DEPTH) ? p - PTR_W'(RESULT_DEPTH) : p;
        return t[RIDX_W-1:0];
    endfunction

    always_comb begin
        logic [PTR_W-1:0] w;
        used = (wr_reg >= rd_reg) ? {1'b0, wr_reg} - {1'b0, rd_reg}
                                  : {1'b0, wr_reg} + (PTR_W+1)'(2 * RESULT_DEPTH)
                                    - {1'b0, rd_reg};
        w = wr_reg;
        for (int k = 0; k < MAX_PUSH; k++) begin
            ptr_k[k] = w;
            wen_k[k] = (k < 32'(push_in.cnt)) && (32'(used) + k < RESULT_DEPTH);
            if (wen_k[k]) w = inc(w);
        end
        wr_next = w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= '0;
            wr_reg <= '0;
            for (int i = 0; i < RESULT_DEPTH; i++) mem_reg[i] <= '0;
        end else if (en) begin
            if (pop && rd_reg != wr_reg) rd_reg <= inc(rd_reg);
            wr_reg <= wr_next;
            for (int k = 0; k < MAX_PUSH; k++)
                if (wen_k[k]) mem_reg[idx(ptr_k[k])] <= push_in.vals[k];
        end
    end

    assign stat.head     = mem_reg[idx(rd_reg)];
    assign stat.empty    = (rd_reg == wr_reg);
    assign stat.one_left = (inc(rd_reg) == wr_reg);

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used) <= RESULT_DEPTH) else $error("result fifo overfilled");
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        en && pop && !stat.empty && push_in.cnt == '0 |=> $past(rd_reg) != rd_reg)
        else $error("pop did not advance");
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(wr_reg) && $stable(rd_reg)) else $error("pointer moved idle");
`endif
endmodule
`default_nettype wire

// ===== sv/fcce_core.sv =====
// fcce_core: combinational step of the command engine: next state, pushes, result.
// Depends on fcce_pkg.
`default_nettype none
module fcce_core (
    input  wire fcce_pkg::item_t     it,
    input  wire fcce_pkg::state_t    st_i,
    input  wire fcce_pkg::byte_t     prm_i [fcce_pkg::PARAM_DEPTH],
    input  wire fcce_pkg::fifo_stat_t fs,
    output fcce_pkg::state_t         st_o,
    output logic                     pw_en,
    output logic [fcce_pkg::PIDX_W-1:0] pw_idx,
    output fcce_pkg::push_t          q,
    output logic                     pop,
    output fcce_pkg::result_t        res
);
    import fcce_pkg::*;

    state_t s;
    byte_t  p [PARAM_DEPTH];
    logic [2:0] rk;
    logic rdrv;
    byte_t rtrk, rsec, rsd, rv, fval;
    logic [1:0] rden;
    logic fv, cerr;
    logic do_done, do_err, err_full;
    byte_t e1, e2, ehead;

    always_comb begin
        s = st_i;
        for (int i = 0; i < PARAM_DEPTH; i++) p[i] = prm_i[i];
        q = '0; pop = 1'b0; pw_en = 1'b0; pw_idx = '0;
        rk = RQ_NONE; rdrv = 1'b0; rtrk = '0; rsec = '0; rsd = '0; rden = '0;
        rv = '0; fv = 1'b0; fval = '0; cerr = 1'b0;
        do_done = 1'b0; do_err = 1'b0; err_full = 1'b0; e1 = '0; e2 = '0;
        unique case (it.action)
            ACT_BUS_WR: begin
                if (it.reg_offset == OFF_DOR) begin
                    if (it.data_byte[2] && !s.output_reg[2]) begin
                        s.reset_pending = 1'b1;
                        s.delay_count = 12'(LONG_DELAY);
                    end
                    if (!it.data_byte[2]) s.main_status = 8'h80;
                    s.output_reg = it.data_byte;
                    if (it.data_byte[4]) rk = RQ_SEL;
                    else if (it.data_byte[5]) begin rk = RQ_SEL; rdrv = 1'b1; end
                end else if (it.reg_offset == OFF_FIFO) begin
                    if (s.param_total != '0) begin
                        if (s.param_pos >= s.param_total || 32'(s.param_pos) >= PARAM_DEPTH)
                            cerr = 1'b1;
                        else begin
                            pw_en = 1'b1;
                            pw_idx = s.param_pos[PIDX_W-1:0];
                            p[pw_idx] = it.data_byte;
                            s.param_pos = s.param_pos + 4'd1;
                            if (s.param_pos == s.param_total) do_done = 1'b1;
                        end
                    end else if (s.busy) begin
                        cerr = 1'b1;
                    end else begin
                        priority case (it.data_byte)
                            OP_SPECIFY, OP_SEEK, OP_SENSE_DRIVE, OP_RECAL, OP_READ_ID_FM,
                            OP_READ_ID, OP_CONFIGURE, OP_WRITE, OP_READ, OP_VERIFY,
                            OP_FORMAT: begin
                                s.busy = 1'b1; s.opcode = it.data_byte; s.param_pos = '0;
                                s.main_status = (it.data_byte == OP_FORMAT) ? 8'h80 : 8'h90;
                                if (it.data_byte == OP_SPECIFY || it.data_byte == OP_SEEK)
                                    s.param_total = 4'd2;
                                else if (it.data_byte == OP_CONFIGURE) s.param_total = 4'd3;
                                else if (it.data_byte == OP_FORMAT) s.param_total = 4'd5;
                                else if (it.data_byte == OP_WRITE || it.data_byte == OP_READ
                                         || it.data_byte == OP_VERIFY)
                                    s.param_total = 4'd8;
                                else s.param_total = 4'd1;
                            end
                            OP_SENSE_INT: begin
                                s.busy = 1'b1; s.opcode = it.data_byte;
                                s.delay_count = 12'(SHORT_DELAY); s.main_status = 8'h10;
                            end
                            OP_DUMPREG: begin
                                s.opcode = it.data_byte; s.st[0] = 8'h80;
                                q = pushf(q, 8'h80);
                                s.levels[0] = 1'b1; s.busy = 1'b0; s.delay_count = '0;
                                s.main_status = 8'h80;
                            end
                            default: cerr = 1'b1;
                        endcase
                    end
                end else if (it.reg_offset == OFF_CCR) begin
                    s.rate_density = (it.data_byte[1:0] == 2'd0) ? 2'd2 :
                                     (it.data_byte[1:0] == 2'd3) ? 2'd3 : 2'd1;
                end
            end
            ACT_BUS_RD: begin
                if (it.reg_offset == OFF_MSR) begin
                    s.levels[0] = 1'b0;
                    rv = s.main_status;
                end else if (it.reg_offset == OFF_FIFO) begin
                    rv = fs.head;
                    pop = 1'b1;
                    if (fs.empty || fs.one_left) s.main_status = 8'h80;
                    else s.main_status = s.main_status | 8'hC0;
                end
            end
            ACT_TICK: begin
                if (s.delay_count != '0) begin
                    s.delay_count = s.delay_count - 12'd1;
                    if (s.delay_count == '0) begin
                        if (s.reset_pending) begin
                            s.reset_pending = 1'b0; s.main_status = 8'h80; s.busy = 1'b0;
                            s.st[0] = 8'hC0; s.cur_track = '0; s.param_pos = '0;
                            s.param_total = '0; s.levels[0] = 1'b1;
                        end else begin
                            priority case (s.opcode)
                                OP_SPECIFY, OP_CONFIGURE: begin
                                    s.busy = 1'b0; s.main_status = 8'h80;
                                    s.param_total = '0; s.param_pos = '0;
                                end
                                OP_SENSE_DRIVE: begin
                                    s.st[3] = {5'b0, p[0][2:0]} | 8'h28
                                              | ((s.cur_track == '0) ? 8'h10 : 8'h00);
                                    s.busy = 1'b0; q = pushf(q, s.st[3]);
                                    s.main_status = 8'hD0; s.levels[0] = 1'b1;
                                    s.param_total = '0; s.param_pos = '0;
                                end
                                OP_RECAL, OP_SEEK: begin
                                    s.cur_track = (s.opcode == OP_SEEK) ? p[1] : 8'h00;
                                    s.busy = 1'b0; s.main_status = 8'h80;
                                    s.param_total = '0; s.param_pos = '0;
                                    s.st[0] = 8'h20; s.levels[0] = 1'b1;
                                end
                                OP_SENSE_INT: begin
                                    q = pushf(q, s.st[0]); q = pushf(q, s.cur_track);
                                    s.main_status = 8'hD0; s.levels[0] = 1'b1;
                                    s.busy = 1'b0;
                                end
                                OP_WRITE, OP_READ: begin
                                    s.cur_sector = s.cur_sector + 9'd1;
                                    if (s.cur_sector > {1'b0, p[5]}) s.flags[FL_TC] = 1'b1;
                                    if (s.flags[FL_TC]) begin
                                        q = pushf(q, s.st[0]); q = pushf(q, s.st[1]);
                                        q = pushf(q, s.st[2]); q = pushf(q, s.cur_track);
                                        q = pushf(q, {7'b0, p[0][2]});
                                        q = pushf(q, s.cur_sector[7:0]); q = pushf(q, p[4]);
                                        s.main_status = 8'hD0; s.busy = 1'b0;
                                        s.param_total = '0; s.param_pos = '0;
                                        s.delay_count = '0; s.levels[0] = 1'b1;
                                    end else begin
                                        rk = (s.opcode == OP_WRITE) ? RQ_WRITE : RQ_READ;
                                        rdrv = s.sel_drive; rtrk = s.cur_track;
                                        rsec = s.cur_sector[7:0]; rsd = s.cur_side;
                                        rden = s.rate_density;
                                        if (s.opcode == OP_WRITE) s.levels[1] = 1'b1;
                                    end
                                end
                                OP_READ_ID_FM: begin
                                    s.st[0] = 8'h40 | {5'b0, p[0][2:0]};
                                    s.st[1] = 8'h01; s.st[2] = 8'h01;
                                    s.busy = 1'b0; s.param_total = '0; s.param_pos = '0;
                                    s.levels[0] = 1'b1;
                                end
                                OP_FORMAT: begin
                                    q = pushf(q, s.st[0]); q = pushf(q, s.st[1]);
                                    q = pushf(q, s.st[2]);
                                    q = pushf(q, 8'h00); q = pushf(q, 8'h00);
                                    q = pushf(q, 8'h00); q = pushf(q, 8'h00);
                                    s.main_status = 8'hD0; s.levels[0] = 1'b1;
                                    s.busy = 1'b0; s.param_total = '0; s.param_pos = '0;
                                end
                                OP_VERIFY: begin
                                    s.cur_sector = {1'b0, p[0][7] ? p[7] : p[5]};
                                    q = pushf(q, s.st[0]); q = pushf(q, s.st[1]);
                                    q = pushf(q, s.st[2]); q = pushf(q, s.cur_track);
                                    q = pushf(q, {7'b0, p[0][2]});
                                    q = pushf(q, s.cur_sector[7:0]); q = pushf(q, p[4]);
                                    s.main_status = 8'hD0; s.levels[0] = 1'b1;
                                    s.busy = 1'b0; s.param_total = '0; s.param_pos = '0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            ACT_DISC: begin
                if (!s.flags[FL_TC] && s.flags[FL_READING]) begin
                    if (s.flags[FL_READY]) begin
                        rk = RQ_STOP; rdrv = s.sel_drive;
                        do_err = 1'b1; e1 = 8'h10; e2 = 8'h00; err_full = 1'b1;
                    end else begin
                        s.dma_byte = it.data_byte;
                        s.flags[FL_READY] = 1'b1;
                        s.levels[1] = 1'b1;
                    end
                end
            end
            ACT_DMA_RD, ACT_DMA_WR: begin
                s.levels[1] = 1'b0;
                if (it.action == ACT_DMA_RD) s.flags[FL_READY] = 1'b0;
                if (it.dma_terminal) begin s.flags[FL_TC] = 1'b1; s.st[0] = 8'h00; end
                if (it.action == ACT_DMA_RD) rv = s.dma_byte;
                else begin s.flags[FL_WRITTEN] = 1'b1; s.dma_byte = it.data_byte; end
            end
            ACT_NOTFND:  begin do_err = 1'b1; e1 = 8'h05; e2 = 8'h00; end
            ACT_DATACRC: begin do_err = 1'b1; e1 = 8'h20; e2 = 8'h20; err_full = 1'b1; end
            ACT_HDRCRC:  begin do_err = 1'b1; e1 = 8'h20; e2 = 8'h00; err_full = 1'b1; end
            ACT_WPROT:   begin do_err = 1'b1; e1 = 8'h02; e2 = 8'h00; end
            ACT_SECID: begin
                q = pushf(q, {5'b0, (s.cur_side != '0), 1'b0, s.sel_drive});
                q = pushf(q, 8'h00); q = pushf(q, 8'h00);
                q = pushf(q, it.id_track); q = pushf(q, it.id_side);
                q = pushf(q, it.id_sector); q = pushf(q, it.id_size);
                s.main_status = 8'hD0; s.busy = 1'b0; s.param_total = '0;
                s.param_pos = '0; s.delay_count = '0; s.levels[0] = 1'b1;
            end
            ACT_FINISH: s.delay_count = 12'(FINISH_DELAY);
            ACT_FETCH: begin
                if (s.flags[FL_WRITTEN] || s.flags[FL_TC]) begin
                    if (!it.fetch_last && !s.flags[FL_TC]) s.levels[1] = 1'b1;
                    s.flags[FL_WRITTEN] = 1'b0;
                    fv = 1'b1;
                    fval = s.dma_byte;
                end
            end
            default: ;
        endcase

        ehead = 8'h40 | {5'b0, (s.cur_side != '0), 1'b0, s.sel_drive};
        if (do_err) begin
            q = pushf(q, ehead); q = pushf(q, e1); q = pushf(q, e2);
            if (err_full) begin
                q = pushf(q, s.cur_track); q = pushf(q, s.cur_side);
                q = pushf(q, s.cur_sector[7:0]); q = pushf(q, p[4]);
            end else begin
                q = pushf(q, 8'h00); q = pushf(q, 8'h00);
                q = pushf(q, 8'h00); q = pushf(q, 8'h00);
            end
            s.main_status = 8'hD0; s.busy = 1'b0; s.param_total = '0;
            s.param_pos = '0; s.delay_count = '0; s.levels[0] = 1'b1;
        end

        if (do_done) begin
            s.main_status = s.main_status & 8'h7F;
            s.flags[FL_TC] = 1'b0; s.flags[FL_READY] = 1'b0; s.flags[FL_READING] = 1'b0;
            priority case (s.opcode)
                OP_SPECIFY, OP_SENSE_DRIVE, OP_CONFIGURE: s.delay_count = 12'(SHORT_DELAY);
                OP_RECAL, OP_SEEK: begin
                    s.delay_count = 12'(LONG_DELAY); s.main_status[0] = 1'b1;
                    rk = RQ_SEEK; rdrv = p[0][0];
                    rtrk = (s.opcode == OP_SEEK) ? p[1] : 8'h00;
                end
                OP_WRITE, OP_READ, OP_VERIFY: begin
                    if (s.opcode == OP_READ) s.flags[FL_READING] = 1'b1;
                    s.st[0] = {5'b0, p[0][2:0]}; s.st[1] = '0; s.st[2] = '0;
                    s.cur_track = p[1]; s.cur_side = p[2]; s.cur_sector = {1'b0, p[3]};
                    s.sel_drive = p[0][0];
                    rk = (s.opcode == OP_WRITE) ? RQ_WRITE : RQ_READ;
                    rdrv = s.sel_drive; rtrk = s.cur_track; rsec = s.cur_sector[7:0];
                    rsd = s.cur_side; rden = s.rate_density;
                    if (s.opcode == OP_WRITE) s.levels[1] = 1'b1;
                end
                OP_READ_ID, OP_READ_ID_FM, OP_FORMAT: begin
                    if (s.opcode == OP_READ_ID_FM) s.delay_count = 12'(READ_ID_DELAY);
                    s.st[0] = {5'b0, p[0][2:0]}; s.st[1] = '0; s.st[2] = '0;
                    s.sel_drive = p[0][0];
                    if (s.opcode == OP_READ_ID) begin
                        rk = RQ_RDID; rdrv = s.sel_drive; rtrk = s.cur_track;
                        rsd = s.cur_side; rden = s.rate_density;
                    end
                end
                default: ;
            endcase
        end

        st_o = s;
        res.read_value    = rv;
        res.fetch_valid   = fv;
        res.fetch_value   = fval;
        res.irq_line      = s.levels[0];
        res.dma_line      = s.levels[1];
        res.drive_request = rk;
        res.req_drive     = rdrv;
        res.req_track     = rtrk;
        res.req_sector    = rsec;
        res.req_side      = rsd;
        res.req_density   = rden;
        res.command_error = cerr;
    end
endmodule
`default_nettype wire

// ===== sv/floppy_controller_command_engine_unit.sv =====
// floppy_controller_command_engine_unit: top level; input register, state, result register.
// Depends on fcce_pkg, fcce_core and fcce_rfifo.
//
// Each request passes through an input register and is completed by combinational
// step logic into the result register, so one request is taken per cycle unless
// stalled; its result is presented from the result register. Throughput is set by
// the single step stage; the result register stalls the input side only while a
// result is held against a low m_ready. Up to seven result FIFO pushes are
// written in the same cycle; pushes into a full FIFO are dropped.
`default_nettype none
module floppy_controller_command_engine_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [3:0] s_action,
    input  wire logic [2:0] s_reg_offset,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_dma_terminal,
    input  wire logic [7:0] s_id_track,
    input  wire logic [7:0] s_id_side,
    input  wire logic [7:0] s_id_sector,
    input  wire logic [7:0] s_id_size,
    input  wire logic       s_fetch_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_value,
    output logic            m_fetch_valid,
    output logic [7:0]      m_fetch_value,
    output logic            m_irq_line,
    output logic            m_dma_line,
    output logic [2:0]      m_drive_request,
    output logic            m_req_drive,
    output logic [7:0]      m_req_track,
    output logic [7:0]      m_req_sector,
    output logic [7:0]      m_req_side,
    output logic [1:0]      m_req_density,
    output logic            m_command_error
);
    import fcce_pkg::*;

    logic       in_valid_reg, out_valid_reg, adv, proc;
    item_t      item_reg;
    state_t     st_reg, st_next;
    byte_t      prm_reg [PARAM_DEPTH];
    result_t    res_reg, res_next;
    push_t      pq;
    fifo_stat_t fs;
    logic       pw_en, pop;
    logic [PIDX_W-1:0] pw_idx;

    assign adv     = !out_valid_reg || m_ready;
    assign proc    = in_valid_reg && adv;
    assign s_ready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{s_action, s_reg_offset, s_data_byte, s_dma_terminal, s_id_track,
                          s_id_side, s_id_sector, s_id_size, s_fetch_last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{main_status: 8'h80, rate_density: 2'd2, default: '0};
        end else if (proc) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && pw_en) prm_reg[pw_idx] <= item_reg.data_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) res_reg <= res_next;
    end

    fcce_core u_core (
        .it     (item_reg),
        .st_i   (st_reg),
        .prm_i  (prm_reg),
        .fs     (fs),
        .st_o   (st_next),
        .pw_en  (pw_en),
        .pw_idx (pw_idx),
        .q      (pq),
        .pop    (pop),
        .res    (res_next)
    );

    fcce_rfifo u_rfifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (proc),
        .pop     (pop),
        .push_in (pq),
        .stat    (fs)
    );

    assign m_valid         = out_valid_reg;
    assign m_read_value    = res_reg.read_value;
    assign m_fetch_valid   = res_reg.fetch_valid;
    assign m_fetch_value   = res_reg.fetch_value;
    assign m_irq_line      = res_reg.irq_line;
    assign m_dma_line      = res_reg.dma_line;
    assign m_drive_request = res_reg.drive_request;
    assign m_req_drive     = res_reg.req_drive;
    assign m_req_track     = res_reg.req_track;
    assign m_req_sector    = res_reg.req_sector;
    assign m_req_side      = res_reg.req_side;
    assign m_req_density   = res_reg.req_density;
    assign m_command_error = res_reg.command_error;

`ifndef SYNTHESIS
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready) else $error("input stalled with free result slot");
    a_fill_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg) else $error("request lost");
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && $stable(st_reg))
        else $error("request advanced under stall");
`endif
endmodule
`default_nettype wire
